@@ sv/ecgrp_pkg.sv @@
// shared types and constants for the r-peak classifier
package ecgrp_pkg;

  localparam int unsigned PeakDepth    = 64;
  localparam int unsigned AvgIntervals = 8;
  localparam int unsigned PtrW         = $clog2(PeakDepth);
  localparam int unsigned FillW        = $clog2(PeakDepth + 1);
  localparam int unsigned AvgCntW      = $clog2(AvgIntervals + 1);

  // peak types stored in the ring
  localparam logic [1:0] TyPeak = 2'd0;
  localparam logic [1:0] TyR    = 2'd1;
  localparam logic [1:0] TyReg  = 2'd2;

  // result classes
  localparam logic [2:0] ClsNone   = 3'd0;
  localparam logic [2:0] ClsNoise  = 3'd1;
  localparam logic [2:0] ClsReg    = 3'd2;
  localparam logic [2:0] ClsIrreg  = 3'd3;
  localparam logic [2:0] ClsSearch = 3'd4;

  // q10 constants
  localparam logic [10:0] K0125 = 11'd128;
  localparam logic [10:0] K0875 = 11'd896;
  localparam logic [10:0] K025  = 11'd256;
  localparam logic [10:0] K075  = 11'd768;
  localparam logic [10:0] K092  = 11'd942;
  localparam logic [10:0] K116  = 11'd1187;
  localparam logic [10:0] K166  = 11'd1699;

  // sequencer states
  typedef enum logic [4:0] {
    StIdle, StWrite, StRrRd, StRrWait, StRrChk, StDecide,
    StMarkHead, StSigMul, StSigAdd, StNoiseMul, StNoiseAdd,
    StSbRd, StSbWait, StSbChk, StSbSig, StSbSigAdd,
    StAvgStart, StAvgRd, StAvgWait, StAvgChk, StDiv, StAvgDone,
    StLimLo, StLimHi, StLimMiss, StThMul, StThAdd, StOut
  } state_e;

  // multiply-accumulate command
  typedef struct packed {
    logic        clr;
    logic        en;
    logic [10:0] k;
    logic [31:0] x;
  } mac_cmd_t;

endpackage

@@ sv/ecg_r_peak_classifier.sv @@
// top level of the r-peak classifier with its sequencer
// Each transaction is one window; a window with no local maximum goes straight to StOut and
// has its result offered from the out_valid register. A detected peak is handled by a
// sequencer that walks the 64-entry peak ring through a registered-read memory with separate
// read and write ports and drives a shared 11x32 multiply-accumulate unit and a divider. Ring
// walks find the last regular peak, run a searchback, and sum the interval averages (two
// after a regular peak, one after a searchback). The block takes no new item until the
// result has been taken. No clearing pass is needed after reset.
module ecg_r_peak_classifier
  import ecgrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] win0_i,
  input  logic [15:0] win1_i,
  input  logic [15:0] win2_i,
  input  logic [15:0] win3_i,
  input  logic [15:0] win4_i,
  input  logic [15:0] win5_i,
  input  logic [15:0] win6_i,
  input  logic [15:0] peak_value_i,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  peak_class_o,
  output logic [31:0] rr_interval_o,
  output logic [15:0] rr_average_regular_o,
  output logic [15:0] rr_average_all_o,
  output logic [15:0] threshold_primary_o,
  output logic [3:0]  missed_count_o
);

  state_e state_q, state_d;

  logic [3:0]  min_reg_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [15:0] sig_q, sig_d, noise_q, noise_d, th1_q, th1_d, th2_q, th2_d;
  logic [15:0] avg_reg_q, avg_reg_d, avg_all_q, avg_all_d;
  logic [16:0] lim_lo_q, lim_lo_d, lim_hi_q, lim_hi_d, lim_miss_q, lim_miss_d;
  logic [3:0]  miss_q, miss_d, seen_q, seen_d;

  // per-item working registers
  logic [15:0] pv_q, pv_d;
  logic [31:0] now_q, now_d, rr_q, rr_d, clk_t_q, clk_t_d;
  logic [2:0]  cls_q, cls_d;
  logic [FillW-1:0] k_q, k_d;
  logic [35:0] sum_q, sum_d;
  logic [AvgCntW-1:0] n_q, n_d;
  logic [1:0]  mintype_q, mintype_d;
  logic        avg_pass_q, avg_pass_d;   // 0: regular then all, 1: all only
  logic        sb_q, sb_d;
  logic        out_valid_q, out_valid_d;

  // ring port
  logic            we, wr_full;
  logic [PtrW-1:0] waddr, raddr;
  logic [1:0]      wtype;
  logic [31:0]     rtime;
  logic [15:0]     rvalue;
  logic [1:0]      rtype;

  mac_cmd_t    mac_cmd;
  logic [16:0] mac_q10;
  logic        div_start, div_busy;
  logic [15:0] div_quo;

  logic        is_peak, in_acc;
  logic [PtrW-1:0] slot_k;
  logic [31:0] diff;

  assign is_peak = (win0_i < win1_i) && (win1_i < win2_i) && (win2_i < win3_i) &&
                   (win3_i > win4_i) && (win4_i > win5_i) && (win5_i > win6_i);
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign in_acc = in_valid_i && !in_stall_o;

  // slot of the k-th newest entry
  assign slot_k = head_q - PtrW'(1) - k_q[PtrW-1:0];
  assign diff   = clk_t_q - rtime;

  ecgrp_ring u_ring (
    .clk_i    (clk_i),
    .we_i     (we),
    .wr_full_i(wr_full),
    .waddr_i  (waddr),
    .wtime_i  (now_q - 32'd1),
    .wvalue_i (pv_q),
    .wtype_i  (wtype),
    .raddr_i  (raddr),
    .rtime_o  (rtime),
    .rvalue_o (rvalue),
    .rtype_o  (rtype)
  );

  ecgrp_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (mac_cmd),
    .q10_o (mac_q10)
  );

  ecgrp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q),
    .den_i  (n_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // sequencer next state and datapath
  always_comb begin
    state_d = state_q;
    head_d = head_q; fill_d = fill_q;
    sig_d = sig_q; noise_d = noise_q; th1_d = th1_q; th2_d = th2_q;
    avg_reg_d = avg_reg_q; avg_all_d = avg_all_q;
    lim_lo_d = lim_lo_q; lim_hi_d = lim_hi_q; lim_miss_d = lim_miss_q;
    miss_d = miss_q; seen_d = seen_q;
    pv_d = pv_q; now_d = now_q; rr_d = rr_q; clk_t_d = clk_t_q; cls_d = cls_q;
    k_d = k_q; sum_d = sum_q; n_d = n_q;
    mintype_d = mintype_q; avg_pass_d = avg_pass_q; sb_d = sb_q;
    out_valid_d = out_valid_q;
    we = 1'b0; wr_full = 1'b0; waddr = head_q; wtype = TyPeak;
    raddr = slot_k;
    mac_cmd = '0;
    div_start = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          pv_d = peak_value_i;
          now_d = sample_time_i;
          cls_d = ClsNone;
          rr_d = '0;
          sb_d = 1'b0;
          state_d = is_peak ? StWrite : StOut;
        end
      end
      StWrite: begin
        we = 1'b1; wr_full = 1'b1;
        wtype = (pv_q > th1_q) ? TyR : TyPeak;
        head_d = head_q + PtrW'(1);
        if (fill_q != FillW'(PeakDepth)) fill_d = fill_q + FillW'(1);
        k_d = FillW'(1);
        clk_t_d = '0;
        state_d = StRrRd;
      end
      StRrRd: begin
        if (k_q >= fill_q) begin
          rr_d = now_q - clk_t_q;
          state_d = StDecide;
        end else begin
          state_d = StRrWait;
        end
      end
      StRrWait: state_d = StRrChk;
      StRrChk: begin
        if (rtype == TyReg) begin
          rr_d = now_q - rtime;
          state_d = StDecide;
        end else begin
          k_d = k_q + FillW'(1);
          state_d = StRrRd;
        end
      end
      StDecide: begin
        if (pv_q > th1_q) begin
          if (({15'd0, lim_lo_q} < rr_q) && (rr_q < {15'd0, lim_hi_q})) begin
            cls_d = ClsReg;
            if (miss_q != 4'd0) miss_d = miss_q - 4'd1;
            state_d = StMarkHead;
          end else if ({15'd0, lim_miss_q} < rr_q) begin
            cls_d = ClsSearch;
            k_d = '0;
            state_d = StSbRd;
          end else begin
            cls_d = ClsIrreg;
            if (miss_q < 4'd10) miss_d = miss_q + 4'd1;
            state_d = StOut;
          end
        end else begin
          cls_d = ClsNoise;
          state_d = StNoiseMul;
        end
      end
      StMarkHead: begin
        we = 1'b1; waddr = head_q - PtrW'(1); wtype = TyReg;
        if (seen_q != 4'd15) seen_d = seen_q + 4'd1;
        if (((seen_q != 4'd15) ? seen_q + 4'd1 : seen_q) >= min_reg_q) begin
          state_d = StSigMul;
        end else begin
          state_d = StOut;
        end
      end
      StSigMul: begin
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K0125, x: {16'd0, pv_q}};
        state_d = StSigAdd;
      end
      StSigAdd: begin
        mac_cmd = '{clr: 1'b0, en: 1'b1, k: K0875, x: {16'd0, sig_q}};
        state_d = StAvgStart;
        mintype_d = TyReg; avg_pass_d = 1'b0;
      end
      StNoiseMul: begin
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K0125, x: {16'd0, pv_q}};
        state_d = StNoiseAdd;
      end
      StNoiseAdd: begin
        mac_cmd = '{clr: 1'b0, en: 1'b1, k: K0875, x: {16'd0, noise_q}};
        state_d = StThMul;
      end
      // searchback: newest first, first value above thresh_two
      StSbRd: begin
        if (k_q >= fill_q) begin
          state_d = StOut;
        end else begin
          state_d = StSbWait;
        end
      end
      StSbWait: state_d = StSbChk;
      StSbChk: begin
        if (rvalue > th2_q) begin
          sb_d = 1'b1;
          we = 1'b1; waddr = slot_k; wtype = TyReg;
          if (rtype != TyReg && seen_q != 4'd15) seen_d = seen_q + 4'd1;
          pv_d = rvalue;
          state_d = StSbSig;
        end else begin
          k_d = k_q + FillW'(1);
          state_d = StSbRd;
        end
      end
      StSbSig: begin
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K025, x: {16'd0, pv_q}};
        state_d = StSbSigAdd;
      end
      StSbSigAdd: begin
        mac_cmd = '{clr: 1'b0, en: 1'b1, k: K075, x: {16'd0, sig_q}};
        mintype_d = TyR; avg_pass_d = 1'b1;
        state_d = StAvgStart;
      end
      // interval average walk
      StAvgStart: begin
        if (!sb_q && avg_pass_q == 1'b0 && mintype_q == TyReg) sig_d = mac_q10[15:0];
        if (sb_q && mintype_q == TyR && avg_pass_q) sig_d = mac_q10[15:0];
        sum_d = '0; n_d = '0; k_d = '0;
        state_d = StAvgRd;
      end
      StAvgRd: begin
        if (k_q >= fill_q || n_q == AvgCntW'(AvgIntervals)) begin
          state_d = StAvgDone;
          if (n_q != '0) begin
            div_start = 1'b1;
            state_d = StDiv;
          end
        end else begin
          state_d = StAvgWait;
        end
      end
      StAvgWait: state_d = StAvgChk;
      StAvgChk: begin
        if (k_q == '0) begin
          clk_t_d = rtime;
        end else if (rtype >= mintype_q) begin
          sum_d = sum_q + {4'd0, diff};
          n_d = n_q + AvgCntW'(1);
          clk_t_d = rtime;
        end
        k_d = k_q + FillW'(1);
        state_d = StAvgRd;
      end
      StDiv: begin
        if (!div_busy) state_d = StAvgDone;
      end
      StAvgDone: begin
        if (mintype_q == TyReg) begin
          avg_reg_d = (n_q == '0) ? 16'd0 : div_quo;
          mintype_d = TyR;
          state_d = StAvgStart;
        end else begin
          avg_all_d = (n_q == '0) ? 16'd0 : div_quo;
          state_d = StLimLo;
        end
      end
      StLimLo: begin
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K092,
                    x: {16'd0, sb_q ? avg_all_q : avg_reg_q}};
        state_d = StLimHi;
      end
      StLimHi: begin
        lim_lo_d = mac_q10;
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K116,
                    x: {16'd0, sb_q ? avg_all_q : avg_reg_q}};
        state_d = StLimMiss;
      end
      StLimMiss: begin
        lim_hi_d = mac_q10;
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K166,
                    x: {16'd0, sb_q ? avg_all_q : avg_reg_q}};
        state_d = StThMul;
      end
      StThMul: begin
        if (cls_q == ClsNoise) noise_d = mac_q10[15:0];
        else lim_miss_d = mac_q10;
        mac_cmd = '{clr: 1'b1, en: 1'b1, k: K075,
                    x: {16'd0, (cls_q == ClsNoise) ? mac_q10[15:0] : noise_q}};
        state_d = StThAdd;
      end
      StThAdd: begin
        mac_cmd = '{clr: 1'b0, en: 1'b1, k: K025, x: {16'd0, sig_q}};
        state_d = StOut;
      end
      StOut: begin
        if (cls_q == ClsNoise || (cls_q == ClsReg && seen_q >= min_reg_q) || sb_q) begin
          th1_d = mac_q10[15:0];
          if (cls_q != ClsReg) th2_d = {1'b0, mac_q10[15:1]};
        end
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      min_reg_q <= 4'd3;
      head_q <= '0; fill_q <= '0;
      sig_q <= '0; noise_q <= '0; th1_q <= 16'd2000; th2_q <= '0;
      avg_reg_q <= 16'd250; avg_all_q <= 16'd250;
      lim_lo_q <= 17'd100; lim_hi_q <= 17'd200; lim_miss_q <= 17'd400;
      miss_q <= '0; seen_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) min_reg_q <= cfg_wdata_i;
      head_q <= head_d; fill_q <= fill_d;
      sig_q <= sig_d; noise_q <= noise_d; th1_q <= th1_d; th2_q <= th2_d;
      avg_reg_q <= avg_reg_d; avg_all_q <= avg_all_d;
      lim_lo_q <= lim_lo_d; lim_hi_q <= lim_hi_d; lim_miss_q <= lim_miss_d;
      miss_q <= miss_d; seen_q <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= ClsNone; sb_q <= 1'b0; k_q <= '0; n_q <= '0;
      mintype_q <= TyReg; avg_pass_q <= 1'b0;
    end else begin
      cls_q <= cls_d; sb_q <= sb_d; k_q <= k_d; n_q <= n_d;
      mintype_q <= mintype_d; avg_pass_q <= avg_pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= pv_d; now_q <= now_d; rr_q <= rr_d; clk_t_q <= clk_t_d;
    sum_q <= sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign peak_class_o = cls_q;
  assign rr_interval_o = rr_q;
  assign rr_average_regular_o = avg_reg_q;
  assign rr_average_all_o = avg_all_q;
  assign threshold_primary_o = th1_q;
  assign missed_count_o = miss_q;

`ifndef NO_ASSERTIONS
  // a result is only offered while the sequencer rests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StIdle) else $error("result while busy");
  // the miss counter never passes its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q <= 4'd10) else $error("miss counter overflow");
  // an accepted item always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != StIdle) else $error("item dropped");
  // the ring fill count never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(PeakDepth)) else $error("fill overflow");
`endif

endmodule

@@ sv/ecgrp_mac.sv @@
// shared multiply-accumulate unit for q10 updates and limits
module ecgrp_mac
  import ecgrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_cmd_t    cmd_i,
  output logic [16:0] q10_o
);

  logic [44:0] acc_q, acc_d;
  logic [43:0] prod;

  // one 11x32 product per cycle
  assign prod = {33'd0, cmd_i.k} * {12'd0, cmd_i.x};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.en) begin
      acc_d = (cmd_i.clr ? 45'd0 : acc_q) + {1'b0, prod};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // 17 bits so the scaled rr limits keep their top bit
  assign q10_o = acc_q[26:10];

endmodule

@@ sv/ecgrp_div.sv @@
// restoring divider for the interval average, one quotient bit per cycle
module ecgrp_div
  import ecgrp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [35:0]        num_i,
  input  logic [AvgCntW-1:0] den_i,
  output logic               busy_o,
  output logic [15:0]        quo_o
);

  logic [35:0]        quo_q, quo_d;
  logic [AvgCntW:0]   rem_q, rem_d;
  logic [AvgCntW-1:0] den_q, den_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [AvgCntW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[AvgCntW-1:0], quo_q[35]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd36;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[34:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[34:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  // saturate to 16 bits
  assign quo_o  = (quo_q[35:16] != '0) ? 16'hFFFF : quo_q[15:0];

endmodule

@@ sv/ecgrp_ring.sv @@
// ring memory of recent peaks: times, values and types
module ecgrp_ring
  import ecgrp_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic            wr_full_i,
  input  logic [PtrW-1:0] waddr_i,
  input  logic [31:0]     wtime_i,
  input  logic [15:0]     wvalue_i,
  input  logic [1:0]      wtype_i,
  input  logic [PtrW-1:0] raddr_i,
  output logic [31:0]     rtime_o,
  output logic [15:0]     rvalue_o,
  output logic [1:0]      rtype_o
);

  logic [31:0] times_mem [PeakDepth];
  logic [15:0] values_mem [PeakDepth];
  logic [1:0]  types_mem [PeakDepth];

  // write full entry or type only
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      types_mem[waddr_i] <= wtype_i;
      if (wr_full_i) begin
        times_mem[waddr_i]  <= wtime_i;
        values_mem[waddr_i] <= wvalue_i;
      end
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rtime_o  <= times_mem[raddr_i];
    rvalue_o <= values_mem[raddr_i];
    rtype_o  <= types_mem[raddr_i];
  end

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the r-peak classifier
module testbench;
  import ecgrp_pkg::*;

  typedef struct packed {
    logic [2:0]  cls;
    logic [31:0] rr;
    logic [15:0] avg_reg;
    logic [15:0] avg_all;
    logic [15:0] th1;
    logic [3:0]  missed;
  } beat_res_t;

  typedef struct {
    logic [15:0] w [7];
    logic [15:0] pv;
    logic [31:0] t;
  } window_t;

  // detection state mirror and expected results
  class beat_scoreboard;
    logic [31:0] ptime [PeakDepth];
    logic [15:0] pval [PeakDepth];
    logic [1:0]  ptype [PeakDepth];
    int unsigned head, fill;
    int unsigned sig_lvl, noise_lvl, th1, th2, avg_reg, avg_all;
    int unsigned lim_lo, lim_hi, lim_miss, missed, reg_seen, min_reg;
    beat_res_t   pending [$];
    int          errors;

    function void clear();
      head = 0; fill = 0; sig_lvl = 0; noise_lvl = 0; th1 = 2000; th2 = 0;
      avg_reg = 250; avg_all = 250; lim_lo = 100; lim_hi = 200; lim_miss = 400;
      missed = 0; reg_seen = 0; min_reg = 3; errors = 0;
      pending.delete();
    endfunction

    function int unsigned nth_slot(int unsigned k);
      return (head + 2 * PeakDepth - 1 - k) % PeakDepth;
    endfunction

    function int unsigned rr_mean(logic [1:0] min_ty);
      longint unsigned acc;
      int unsigned n, s;
      logic [31:0] clk_t;
      acc = 0; n = 0;
      if (fill == 0) return 0;
      clk_t = ptime[nth_slot(0)];
      for (int unsigned k = 1; k < fill; k++) begin
        s = nth_slot(k);
        if (ptype[s] >= min_ty) begin
          acc += 32'(clk_t - ptime[s]);
          clk_t = ptime[s];
          n++;
          if (n == AvgIntervals) break;
        end
      end
      if (n == 0) return 0;
      acc = acc / n;
      return (acc > 65535) ? 65535 : int'(acc);
    endfunction

    function void set_limits(int unsigned a);
      lim_lo = (942 * a) >> 10; lim_hi = (1187 * a) >> 10; lim_miss = (1699 * a) >> 10;
    endfunction

    function void promote(int unsigned s);
      if (ptype[s] != TyReg && reg_seen < 15) reg_seen++;
      ptype[s] = TyReg;
    endfunction

    // note an accepted window and queue its expected result
    function void note_window(window_t x);
      beat_res_t r;
      logic [31:0] rr, last;
      int unsigned hs, s;
      r.cls = ClsNone; rr = 0;
      if (x.w[0] < x.w[1] && x.w[1] < x.w[2] && x.w[2] < x.w[3] &&
          x.w[3] > x.w[4] && x.w[4] > x.w[5] && x.w[5] > x.w[6]) begin
        hs = head; last = 0;
        ptime[hs] = x.t - 1; pval[hs] = x.pv; ptype[hs] = TyPeak;
        head = (head + 1) % PeakDepth;
        if (fill < PeakDepth) fill++;
        for (int unsigned k = 1; k < fill; k++) begin
          s = nth_slot(k);
          if (ptype[s] == TyReg) begin
            last = ptime[s];
            break;
          end
        end
        rr = x.t - last;
        if (x.pv > th1) begin
          ptype[hs] = TyR;
          if (lim_lo < rr && rr < lim_hi) begin
            r.cls = ClsReg;
            if (missed > 0) missed--;
            promote(hs);
            if (reg_seen >= min_reg) begin
              sig_lvl = (128 * x.pv + 896 * sig_lvl) >> 10;
              avg_reg = rr_mean(TyReg);
              avg_all = rr_mean(TyR);
              set_limits(avg_reg);
              th1 = (768 * noise_lvl + 256 * sig_lvl) >> 10;
            end
          end else if (lim_miss < rr) begin
            r.cls = ClsSearch;
            for (int unsigned k = 0; k < fill; k++) begin
              s = nth_slot(k);
              if (pval[s] > th2) begin
                promote(s);
                sig_lvl = (256 * pval[s] + 768 * sig_lvl) >> 10;
                avg_all = rr_mean(TyR);
                set_limits(avg_all);
                th1 = (768 * noise_lvl + 256 * sig_lvl) >> 10;
                th2 = th1 >> 1;
                break;
              end
            end
          end else begin
            r.cls = ClsIrreg;
            if (missed < 10) missed++;
          end
        end else begin
          r.cls = ClsNoise;
          noise_lvl = (128 * x.pv + 896 * noise_lvl) >> 10;
          th1 = (768 * noise_lvl + 256 * sig_lvl) >> 10;
          th2 = th1 >> 1;
        end
      end
      r.rr = rr; r.avg_reg = avg_reg[15:0]; r.avg_all = avg_all[15:0];
      r.th1 = th1[15:0]; r.missed = missed[3:0];
      pending.push_back(r);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    // check one accepted result against the oldest expectation
    task automatic check_result(beat_res_t got);
      beat_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.cls !== e.cls) report("peak_class", got.cls, e.cls);
      if (got.rr !== e.rr) report("rr_interval", got.rr, e.rr);
      if (got.avg_reg !== e.avg_reg) report("rr_average_regular", got.avg_reg, e.avg_reg);
      if (got.avg_all !== e.avg_all) report("rr_average_all", got.avg_all, e.avg_all);
      if (got.th1 !== e.th1) report("threshold_primary", got.th1, e.th1);
      if (got.missed !== e.missed) report("missed_count", got.missed, e.missed);
    endtask
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [3:0]  cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [15:0] win_d [7] = '{default: 0};
  logic [15:0] peak_value_i = 0;
  logic [31:0] sample_time_i = 1;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  peak_class_o;
  logic [31:0] rr_interval_o;
  logic [15:0] rr_average_regular_o, rr_average_all_o, threshold_primary_o;
  logic [3:0]  missed_count_o;

  beat_scoreboard sb = new();
  logic [31:0] now_t = 1000;
  bit          hold_rx = 0;

  ecg_r_peak_classifier dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .win0_i(win_d[0]), .win1_i(win_d[1]), .win2_i(win_d[2]), .win3_i(win_d[3]),
    .win4_i(win_d[4]), .win5_i(win_d[5]), .win6_i(win_d[6]),
    .peak_value_i, .sample_time_i, .out_valid_o, .out_stall_i, .peak_class_o,
    .rr_interval_o, .rr_average_regular_o, .rr_average_all_o, .threshold_primary_o,
    .missed_count_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // send one window and wait for acceptance; valid drops only when a gap follows
  task automatic send_window(window_t x, bit no_gaps);
    int unsigned g;
    g = no_gaps ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    for (int i = 0; i < 7; i++) win_d[i] <= x.w[i];
    peak_value_i <= x.pv;
    sample_time_i <= x.t;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_window(x);
  endtask

  // build a window, with or without a clean local maximum at the centre
  function automatic window_t make_window(bit peaked, logic [15:0] pv, logic [31:0] t);
    window_t x;
    logic [15:0] top;
    if (peaked) begin
      top = 16'($urandom_range(7, 65535));
      x.w[3] = top;
      x.w[2] = 16'($urandom_range(2, top - 1)); x.w[1] = 16'($urandom_range(1, x.w[2] - 1));
      x.w[0] = 16'($urandom_range(0, x.w[1] - 1));
      x.w[4] = 16'($urandom_range(2, top - 1)); x.w[5] = 16'($urandom_range(1, x.w[4] - 1));
      x.w[6] = 16'($urandom_range(0, x.w[5] - 1));
    end else begin
      for (int i = 0; i < 7; i++) x.w[i] = 16'($urandom);
    end
    x.pv = pv; x.t = t;
    return x;
  endfunction

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_min_regular(logic [3:0] v);
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.min_reg = v;
  endtask

  // one beat of a plausible rhythm: r-peak, noise, or nothing
  task automatic rhythm_beat(bit no_gaps);
    int unsigned pick;
    window_t x;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      now_t += $urandom_range(0, 3) == 0 ? $urandom_range(20, 700) : $urandom_range(150, 320);
      x = make_window(1, 16'($urandom_range(sb.th1 + 1 > 65535 ? 65535 : sb.th1 + 1, 65535)),
                      now_t);
    end else if (pick < 8) begin
      now_t += $urandom_range(1, 80);
      x = make_window(1, 16'($urandom_range(0, sb.th1)), now_t);
    end else begin
      now_t += $urandom_range(1, 40);
      x = make_window(0, 16'($urandom), now_t);
    end
    send_window(x, no_gaps);
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_stall_i <= 1;
      else if ($urandom_range(0, 3) == 0) out_stall_i <= 1;
      else if ($urandom_range(0, 20) == 0) out_stall_i <= 1;
      else out_stall_i <= 0;
    end
  end

  // result monitor
  initial begin
    beat_res_t r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        r.cls = peak_class_o; r.rr = rr_interval_o; r.avg_reg = rr_average_regular_o;
        r.avg_all = rr_average_all_o; r.th1 = threshold_primary_o; r.missed = missed_count_o;
        sb.check_result(r);
      end
    end
  end

  initial begin
    window_t x;
    logic [3:0] settings [4] = '{4'd0, 4'd15, 4'd1, 4'd5};
    sb.clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: field extremes, noise, regular, irregular, searchback, time wrap
    x.w = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd2, 16'd1, 16'd0};
    x.pv = 16'hFFFF; x.t = 32'd1; send_window(x, 0);
    x.w = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd2, 16'd1, 16'd0};
    x.pv = 16'd0; x.t = 32'd0; send_window(x, 0);
    x.w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    x.pv = 16'hFFFF; x.t = 32'hFFFF_FFFF; send_window(x, 0);
    x.w = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    x.pv = 16'd0; x.t = 32'd5; send_window(x, 0);
    for (int i = 0; i < 14; i++) begin
      now_t += (i < 6) ? 32'd160 : (i < 10 ? 32'd60 : 32'd900);
      x = make_window(1, (i % 4 == 3) ? 16'd10 : 16'd60000, now_t);
      send_window(x, 0);
    end
    drain();

    // random rhythm in phases with different register values
    for (int ph = 0; ph < 4; ph++) begin
      write_min_regular(settings[ph]);
      for (int n = 0; n < 120; n++) begin
        if (ph == 1 && n == 30) begin
          // long receiver hold while windows keep coming
          fork
            begin
              hold_rx = 1;
              repeat (400) @(posedge clk_i);
              hold_rx = 0;
            end
            begin
              repeat (4) rhythm_beat(1);
            end
          join
        end
        if (ph == 2 && n == 60) drain();
        rhythm_beat(ph == 3 && n < 30);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
